FILE: rtl/bole_pkg.sv
// Package with the command and status codes and the cell control struct.
`default_nettype none

package bole_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned OpWidth      = 3;
  localparam int unsigned StatusWidth  = 3;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned PosWidth     = 8;
  localparam int unsigned CountWidth   = 9;

  typedef enum logic [OpWidth-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // What every cell of the row does in the current cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_MATCH,
    CELL_SCAN
  } cell_op_e;

  typedef struct packed {
    cell_op_e                      kind;
    logic [PosWidth-1:0]           pos;
    logic [CountWidth-1:0]         count;
    logic signed [ValueWidth-1:0]  key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/bole_if.sv
// Valid/ready channel interfaces for the command and result requests.
`default_nettype none

interface bole_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [bole_pkg::OpWidth-1:0]          op;
  logic signed [bole_pkg::ValueWidth-1:0] item_value;
  logic [bole_pkg::PosWidth-1:0]         item_position;

  modport source (output valid, op, item_value, item_position, input ready);
  modport sink   (input valid, op, item_value, item_position, output ready);
endinterface

interface bole_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [bole_pkg::StatusWidth-1:0]       status;
  logic signed [bole_pkg::ValueWidth-1:0] removed_value;
  logic [bole_pkg::PosWidth-1:0]          found_index;
  logic [bole_pkg::CountWidth-1:0]        entry_count;

  modport source (output valid, status, removed_value, found_index, entry_count,
                  input ready);
  modport sink   (input valid, status, removed_value, found_index, entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/bounded_ordered_list_engine_top.sv
// Top level of the bounded ordered list engine: command decode, scan sequencer, cell row.
// Inserts, deletes, empty searches and bad ops give their result in the cycle after the request
// is taken; a search gives it once the match flags, walking one cell per cycle, bring a match
// or the last entry to cell 0. A new command can be taken in the cycle after an insert or
// delete if the result register is free or being read. Reset clears the count, the sequencer
// and the result valid flag; stored entries are not cleared: positions >= count are never read.
`default_nettype none

module bounded_ordered_list_engine_top #(
  parameter int unsigned DEPTH = bole_pkg::DefaultDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bole_cmd_if.sink   cmd_i,
  bole_rsp_if.source rsp_o
);
  import bole_pkg::*;

  // Index into the row and the entry count, each as narrow as DEPTH allows.
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CountWidth-1:0] DepthCnt = CountWidth'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic                         out_valid_q, out_valid_d;
  logic [StatusWidth-1:0]       out_status_q, out_status_d;
  logic signed [ValueWidth-1:0] out_removed_q, out_removed_d;
  logic [PosWidth-1:0]          out_found_q, out_found_d;
  logic [CountWidth-1:0]        out_count_q, out_count_d;

  cell_ctrl_t                   ctrl;
  logic signed [ValueWidth-1:0] vals_w [DEPTH];
  logic                         match_w [DEPTH];

  logic                         accept;
  logic [CountWidth-1:0]        cnt_ext;
  logic [CountWidth-1:0]        pos_ext;

  // A command is taken only while idle and when the result register is free
  // or is being emptied in the same cycle, so a finished command always has
  // a place to put its result.
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cnt_ext     = CountWidth'(cnt_q);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_found_d   = out_found_q;
    out_count_d   = out_count_q;
    pos_ext       = '0;
    ctrl.kind     = CELL_HOLD;
    ctrl.pos      = '0;
    ctrl.count    = cnt_ext;
    ctrl.key      = cmd_i.item_value;

    if (state_q == S_SCAN) begin
      // Cell 0 holds the match flag of entry idx_q; the row shifts each cycle.
      ctrl.kind = CELL_SCAN;
      if (match_w[0]) begin
        state_d       = S_IDLE;
        out_valid_d   = 1'b1;
        out_status_d  = ST_OK;
        out_removed_d = '0;
        out_found_d   = PosWidth'(idx_q);
        out_count_d   = cnt_ext;
      end else if (CntW'(idx_q) + CntW'(1) == cnt_q) begin
        state_d       = S_IDLE;
        out_valid_d   = 1'b1;
        out_status_d  = ST_NOT_FOUND;
        out_removed_d = '0;
        out_found_d   = '0;
        out_count_d   = cnt_ext;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end else if (accept) begin
      out_valid_d   = 1'b1;
      out_removed_d = '0;
      out_found_d   = '0;
      out_count_d   = cnt_ext;
      case (op_e'(cmd_i.op))
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          case (op_e'(cmd_i.op))
            OP_INS_FRONT: pos_ext = '0;
            OP_INS_BACK:  pos_ext = cnt_ext;
            default:      pos_ext = CountWidth'(cmd_i.item_position);
          endcase
          if (pos_ext > cnt_ext) begin
            out_status_d = ST_RANGE;
          end else if (cnt_ext == DepthCnt) begin
            out_status_d = ST_FULL;
          end else begin
            out_status_d = ST_OK;
            ctrl.kind    = CELL_INSERT;
            ctrl.pos     = pos_ext[PosWidth-1:0];
            cnt_d        = cnt_q + CntW'(1);
            out_count_d  = cnt_ext + CountWidth'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          case (op_e'(cmd_i.op))
            OP_DEL_FRONT: pos_ext = '0;
            OP_DEL_BACK:  pos_ext = cnt_ext - CountWidth'(1);
            default:      pos_ext = CountWidth'(cmd_i.item_position);
          endcase
          if (cnt_q == '0) begin
            out_status_d = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            out_status_d = ST_RANGE;
          end else begin
            out_status_d  = ST_OK;
            out_removed_d = vals_w[pos_ext[IdxW-1:0]];
            ctrl.kind     = CELL_DELETE;
            ctrl.pos      = pos_ext[PosWidth-1:0];
            cnt_d         = cnt_q - CntW'(1);
            out_count_d   = cnt_ext - CountWidth'(1);
          end
        end
        OP_SEARCH: begin
          if (cnt_q == '0) begin
            out_status_d = ST_EMPTY;
          end else begin
            // Every cell compares in parallel; the sequencer then walks the flags.
            out_valid_d = 1'b0;
            ctrl.kind   = CELL_MATCH;
            idx_d       = '0;
            state_d     = S_SCAN;
          end
        end
        default: begin
          out_status_d = ST_RANGE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
    out_found_q   <= out_found_d;
    out_count_q   <= out_count_d;
  end

  // The row of cells: each takes its left neighbor's entry on an insert, its right neighbor's
  // entry on a delete and its right neighbor's match flag on a scan step.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValueWidth-1:0] left_val;
    logic signed [ValueWidth-1:0] right_val;
    logic                         right_match;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = vals_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val   = '0;
      assign right_match = 1'b0;
    end else begin : g_mid_r
      assign right_val   = vals_w[g+1];
      assign right_match = match_w[g+1];
    end

    bole_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .left_value_i  (left_val),
      .right_value_i (right_val),
      .right_match_i (right_match),
      .value_o       (vals_w[g]),
      .match_o       (match_w[g])
    );
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.found_index   = out_found_q;
  assign rsp_o.entry_count   = out_count_q;

endmodule

`default_nettype wire

FILE: rtl/bole_cell.sv
// One list cell: holds one entry and one match flag, shifts with its neighbors.
`default_nettype none

module bole_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                                    clk_i,
  input  wire bole_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic signed [bole_pkg::ValueWidth-1:0] left_value_i,
  input  wire logic signed [bole_pkg::ValueWidth-1:0] right_value_i,
  input  wire logic                              right_match_i,
  output logic signed [bole_pkg::ValueWidth-1:0] value_o,
  output logic                                   match_o
);
  import bole_pkg::*;

  localparam logic [PosWidth-1:0]   IdxPos = PosWidth'(Idx);
  localparam logic [CountWidth-1:0] IdxCnt = CountWidth'(Idx);

  logic signed [ValueWidth-1:0] value_q, value_d;
  logic                         match_q, match_d;

  always_comb begin
    value_d = value_q;
    match_d = match_q;
    case (ctrl_i.kind)
      CELL_INSERT: begin
        if (IdxPos == ctrl_i.pos) begin
          value_d = ctrl_i.key;
        end else if (IdxPos > ctrl_i.pos) begin
          value_d = left_value_i;
        end
      end
      CELL_DELETE: begin
        if (IdxPos >= ctrl_i.pos) begin
          value_d = right_value_i;
        end
      end
      CELL_MATCH: begin
        match_d = (value_q == ctrl_i.key) && (IdxCnt < ctrl_i.count);
      end
      CELL_SCAN: begin
        match_d = right_match_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

`default_nettype wire
